// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CMUV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
`define CMUV_NEVER(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(prop)) \
      else $error("%m: forbidden condition seen");
`else
`define CMUV_ASSERT(lbl, clk, rst, prop)
`define CMUV_NEVER(lbl, clk, rst, prop)
`endif

`endif

// ----- rtl/core/cmuv_pkg.sv -----
// ---------------------------------------------------------------------------
// cmuv_pkg
// Shared constants and types for the cube-map uv projection block.
// ---------------------------------------------------------------------------
package cmuv_pkg;

   localparam int COORD_WIDTH_DEF  = 32;
   localparam int UV_FRAC_BITS_DEF = 16;
   localparam int FIFO_DEPTH_DEF   = 4;
   localparam int TEX_W            = 16;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

endpackage

// ----- rtl/core/cmuv_front.sv -----
// ---------------------------------------------------------------------------
// cmuv_front
// Takes positions, picks the major face and forms dividends and divisor.
// ---------------------------------------------------------------------------
module cmuv_front #(
   parameter int COORD_WIDTH = cmuv_pkg::COORD_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [COORD_WIDTH-1:0]     req_pos_x,
   input  logic [COORD_WIDTH-1:0]     req_pos_y,
   input  logic [COORD_WIDTH-1:0]     req_pos_z,
   input  cmuv_pkg::fifo_stat_type    fifo_stat,
   output logic                       push,
   output logic [COORD_WIDTH:0]       num_u,
   output logic [COORD_WIDTH:0]       num_v,
   output logic [COORD_WIDTH:0]       den,
   output logic                       degen
);

   localparam int CW = COORD_WIDTH;

   logic          v_ff, v_in, adv;
   logic [CW-1:0] x_ff, y_ff, z_ff, ax_ff, ay_ff, az_ff;
   logic          xmaj, ymaj, zmaj;
   logic [CW-1:0] m;
   logic [CW:0]   cx, cy, cz, uc, vc;
   logic [CW+1:0] su, sv;

   assign adv       = !v_ff || !fifo_stat.full;
   assign req_stall = !adv;
   assign v_in      = adv ? req_valid : v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      if (adv && req_valid) begin
         x_ff  <= req_pos_x;
         y_ff  <= req_pos_y;
         z_ff  <= req_pos_z;
         ax_ff <= req_pos_x[CW-1] ? (~req_pos_x + 1'b1) : req_pos_x;
         ay_ff <= req_pos_y[CW-1] ? (~req_pos_y + 1'b1) : req_pos_y;
         az_ff <= req_pos_z[CW-1] ? (~req_pos_z + 1'b1) : req_pos_z;
      end
   end

   assign cx = {x_ff[CW-1], x_ff};
   assign cy = {y_ff[CW-1], y_ff};
   assign cz = {z_ff[CW-1], z_ff};

   assign xmaj = (ax_ff >= ay_ff) && (ax_ff >= az_ff);
   assign ymaj = (ay_ff >= ax_ff) && (ay_ff >= az_ff);
   assign zmaj = (az_ff >= ax_ff) && (az_ff >= ay_ff);

   // later faces win ties: Z over Y over X; zero counts as negative
   always_comb begin
      if (zmaj) begin
         m  = az_ff;
         uc = (!z_ff[CW-1] && (z_ff != '0)) ? cx : -cx;
         vc = cy;
      end else if (ymaj) begin
         m  = ay_ff;
         uc = cx;
         vc = (!y_ff[CW-1] && (y_ff != '0)) ? -cz : cz;
      end else begin
         m  = ax_ff;
         uc = (!x_ff[CW-1] && (x_ff != '0)) ? -cz : cz;
         vc = cy;
      end
   end

   assign su    = {uc[CW], uc} + {2'b00, m};
   assign sv    = {vc[CW], vc} + {2'b00, m};
   assign num_u = su[CW:0];
   assign num_v = sv[CW:0];
   assign den   = {m, 1'b0};
   assign degen = (m == '0);
   assign push  = v_ff && !fifo_stat.full;

endmodule

// ----- rtl/core/cmuv_fifo.sv -----
// ---------------------------------------------------------------------------
// cmuv_fifo
// Short queue between the classifying front and the divider back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cmuv_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cmuv_pkg::FIFO_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        wdata,
   input  logic                    pop,
   output logic [WIDTH-1:0]        rdata,
   output cmuv_pkg::fifo_stat_type stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, rp_ff, wp_in, rp_in;
   logic [NW-1:0]    cnt_ff, cnt_in;

   assign wp_in  = push ? ((wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
   assign rp_in  = pop  ? ((rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
   assign cnt_in = cnt_ff + NW'(push) - NW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

   assign rdata      = mem_ff[rp_ff];
   assign stat.full  = (cnt_ff == NW'(DEPTH));
   assign stat.empty = (cnt_ff == '0);

   `CMUV_NEVER(a_push_full, clock, reset, push && stat.full)
   `CMUV_NEVER(a_pop_empty, clock, reset, pop && stat.empty)
   `CMUV_ASSERT(a_cnt_range, clock, reset, cnt_ff <= NW'(DEPTH))

endmodule

// ----- rtl/core/cmuv_back.sv -----
// ---------------------------------------------------------------------------
// cmuv_back
// Pipelined restoring divider, one quotient bit per stage, and result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cmuv_back #(
   parameter int COORD_WIDTH  = cmuv_pkg::COORD_WIDTH_DEF,
   parameter int UV_FRAC_BITS = cmuv_pkg::UV_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmuv_pkg::fifo_stat_type       fifo_stat,
   output logic                          pop,
   input  logic [COORD_WIDTH:0]          num_u,
   input  logic [COORD_WIDTH:0]          num_v,
   input  logic [COORD_WIDTH:0]          den,
   input  logic                          degen,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cmuv_pkg::TEX_W-1:0]    rsp_tex_u,
   output logic [cmuv_pkg::TEX_W-1:0]    rsp_tex_v,
   output logic                          rsp_degenerate
);

   localparam int CW = COORD_WIDTH;
   localparam int F  = UV_FRAC_BITS;
   localparam int RW = CW + 2;
   localparam int TW = cmuv_pkg::TEX_W;
   localparam int QW = (F > TW) ? F : TW;

   logic          adv;
   logic [F-1:0]  pv_ff;
   logic [RW-1:0] ru_ff  [F];
   logic [RW-1:0] rv_ff  [F];
   logic [F-1:0]  qu_ff  [F];
   logic [F-1:0]  qv_ff  [F];
   logic [CW:0]   den_ff [F];
   logic [F-1:0]  dg_ff;

   logic          out_v_ff;
   logic [TW-1:0] out_u_ff, out_v_tex_ff;
   logic          out_dg_ff;
   logic [QW-1:0] qux, qvx;

   assign adv = !out_v_ff || !rsp_stall;
   assign pop = adv && !fifo_stat.empty;

   for (genvar i = 0; i < F; i++) begin : g_stage
      logic          vi, di;
      logic [RW-1:0] rui, rvi, rus, rvs, dw;
      logic [F-1:0]  qui, qvi;
      logic [CW:0]   dni;
      logic          bu, bv;

      if (i == 0) begin : g_first
         assign vi  = !fifo_stat.empty;
         assign rui = {1'b0, num_u};
         assign rvi = {1'b0, num_v};
         assign qui = '0;
         assign qvi = '0;
         assign dni = den;
         assign di  = degen;
      end else begin : g_next
         assign vi  = pv_ff[i-1];
         assign rui = ru_ff[i-1];
         assign rvi = rv_ff[i-1];
         assign qui = qu_ff[i-1];
         assign qvi = qv_ff[i-1];
         assign dni = den_ff[i-1];
         assign di  = dg_ff[i-1];
      end

      assign dw  = {1'b0, dni};
      assign rus = {rui[RW-2:0], 1'b0};
      assign rvs = {rvi[RW-2:0], 1'b0};
      assign bu  = (rus >= dw);
      assign bv  = (rvs >= dw);

      always_ff @(posedge clock) begin
         if (reset) begin
            pv_ff[i] <= 1'b0;
         end else if (adv) begin
            pv_ff[i] <= vi;
         end
         if (adv) begin
            ru_ff[i]  <= bu ? (rus - dw) : rus;
            rv_ff[i]  <= bv ? (rvs - dw) : rvs;
            qu_ff[i]  <= {qui[F-2:0], bu};
            qv_ff[i]  <= {qvi[F-2:0], bv};
            den_ff[i] <= dni;
            dg_ff[i]  <= di;
         end
      end
   end

   // quotient of exactly 1.0 comes out as all ones, which is the saturated value
   assign qux = QW'(qu_ff[F-1]);
   assign qvx = QW'(qv_ff[F-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= pv_ff[F-1];
      end
      if (adv) begin
         out_u_ff     <= dg_ff[F-1] ? '0 : qux[TW-1:0];
         out_v_tex_ff <= dg_ff[F-1] ? '0 : qvx[TW-1:0];
         out_dg_ff    <= dg_ff[F-1];
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_tex_u      = out_u_ff;
   assign rsp_tex_v      = out_v_tex_ff;
   assign rsp_degenerate = out_dg_ff;

   `CMUV_ASSERT(a_degen_zero, clock, reset,
      !(out_v_ff && out_dg_ff) || (out_u_ff == '0 && out_v_tex_ff == '0))
   `CMUV_ASSERT(a_den_degen, clock, reset,
      !pv_ff[F-1] || ((den_ff[F-1] == '0) == dg_ff[F-1]))
   `CMUV_ASSERT(a_hold_stall, clock, reset,
      (out_v_ff && rsp_stall) |=> $stable(pv_ff))

endmodule

// ----- rtl/core/cube_map_uv_projection_top.sv -----
// ---------------------------------------------------------------------------
// cube_map_uv_projection_top
// Cube-map face selection and uv projection of vertex positions.
//
//   channel  ports          direction  payload
//   req      req_valid/stall in        pos_x, pos_y, pos_z
//   rsp      rsp_valid/stall out       tex_u, tex_v, degenerate
//
// One transaction per cycle sustained while rsp_stall is low. A result passes
// through the front register, which loads at acceptance, then one queue
// slot, one divider stage per fraction bit and one result register.
// Synchronous reset clears valid and pointer state only; no clearing pass.
// rsp_stall freezes the divider; a four-entry queue absorbs the front side.
// ---------------------------------------------------------------------------
module cube_map_uv_projection_top #(
   parameter int COORD_WIDTH  = cmuv_pkg::COORD_WIDTH_DEF,
   parameter int UV_FRAC_BITS = cmuv_pkg::UV_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [COORD_WIDTH-1:0]      req_pos_x,
   input  logic [COORD_WIDTH-1:0]      req_pos_y,
   input  logic [COORD_WIDTH-1:0]      req_pos_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [cmuv_pkg::TEX_W-1:0]  rsp_tex_u,
   output logic [cmuv_pkg::TEX_W-1:0]  rsp_tex_v,
   output logic                        rsp_degenerate
);

   localparam int CW = COORD_WIDTH;
   localparam int DW = 3 * (CW + 1) + 1;

   cmuv_pkg::fifo_stat_type fstat;
   logic                    push, pop, f_degen, b_degen;
   logic [CW:0]             f_num_u, f_num_v, f_den, b_num_u, b_num_v, b_den;
   logic [DW-1:0]           wdata, rdata;

   cmuv_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_pos_z (req_pos_z),
      .fifo_stat (fstat),
      .push      (push),
      .num_u     (f_num_u),
      .num_v     (f_num_v),
      .den       (f_den),
      .degen     (f_degen)
   );

   assign wdata = {f_num_u, f_num_v, f_den, f_degen};

   cmuv_fifo #(.WIDTH(DW), .DEPTH(cmuv_pkg::FIFO_DEPTH_DEF)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (wdata),
      .pop   (pop),
      .rdata (rdata),
      .stat  (fstat)
   );

   assign {b_num_u, b_num_v, b_den, b_degen} = rdata;

   cmuv_back #(
      .COORD_WIDTH  (COORD_WIDTH),
      .UV_FRAC_BITS (UV_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_stat      (fstat),
      .pop            (pop),
      .num_u          (b_num_u),
      .num_v          (b_num_v),
      .den            (b_den),
      .degen          (b_degen),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_tex_u      (rsp_tex_u),
      .rsp_tex_v      (rsp_tex_v),
      .rsp_degenerate (rsp_degenerate)
   );

endmodule
